// ----- src/kdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlp_pkg: shared constants for the key debounce / long press block
// Key modes, event codes, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

    // Field and register widths
    localparam int unsigned SETTLE_W = 8;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned EVENT_W  = 2;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // Key modes
    localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRESSED  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LONG     = 2'd3;

    // Event codes
    localparam logic [EVENT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EVT_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EVT_LONG  = 2'd2;

    // Register indexes (byte address bit 2)
    localparam logic REG_DEBOUNCE_LIMIT   = 1'b0;
    localparam logic REG_LONG_PRESS_LIMIT = 1'b1;

    // Register reset values
    localparam logic [SETTLE_W-1:0] DEBOUNCE_LIMIT_RST   = 8'd25;
    localparam logic [HOLD_W-1:0]   LONG_PRESS_LIMIT_RST = 16'd100;

endpackage : kdlp_pkg

`default_nettype wire

// ----- src/key_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// key_debounce_long_press: debounce and short/long press classifier
// Four-mode key machine fed one sampled active-low level per word.
// ----------------------------------------------------------------------------
// The block takes one pin sample per clock cycle when not stalled and returns
// one event word per sample, in order: 0 for nothing, 1 when a short press is
// released, 2 once when a press reaches the long-press limit. A sample is
// accepted when i_in_valid is high and o_in_stall is low; its event appears on
// the output register in the next cycle. The key state and the output register
// update in the same cycle, so the throughput is one sample per cycle as long as
// the output side keeps taking words. The debounce and long-press limits are
// set through the APB port at byte addresses 0 and 4 and should be written only
// while the block is idle.
`default_nettype none

module key_debounce_long_press (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Sample input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_pin_level,
    // Event output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [kdlp_pkg::EVENT_W-1:0]           o_press_event,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kdlp_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [kdlp_pkg::DATA_W-1:0]       pwdata,
    output logic [kdlp_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    // Configuration registers
    logic [kdlp_pkg::SETTLE_W-1:0] r_debounce_limit;
    logic [kdlp_pkg::HOLD_W-1:0]   r_long_press_limit;

    // Key state
    logic [kdlp_pkg::MODE_W-1:0]   r_mode,         n_mode;
    logic                          r_prev_level;
    logic [kdlp_pkg::SETTLE_W-1:0] r_settle_count, n_settle_count;
    logic [kdlp_pkg::HOLD_W-1:0]   r_hold_count,   n_hold_count;

    // Output register
    logic                          r_out_valid;
    logic [kdlp_pkg::EVENT_W-1:0]  r_press_event,  n_press_event;

    logic                          in_accept;
    logic                          cfg_write;
    logic [kdlp_pkg::SETTLE_W-1:0] settle_inc;
    logic [kdlp_pkg::HOLD_W-1:0]   hold_inc;

    // Handshake: take a new word when the output slot is free or draining
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_press_event;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == kdlp_pkg::REG_LONG_PRESS_LIMIT) begin
            prdata[kdlp_pkg::HOLD_W-1:0] = r_long_press_limit;
        end else begin
            prdata[kdlp_pkg::SETTLE_W-1:0] = r_debounce_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit   <= kdlp_pkg::DEBOUNCE_LIMIT_RST;
            r_long_press_limit <= kdlp_pkg::LONG_PRESS_LIMIT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == kdlp_pkg::REG_LONG_PRESS_LIMIT) begin
                r_long_press_limit <= pwdata[kdlp_pkg::HOLD_W-1:0];
            end else begin
                r_debounce_limit <= pwdata[kdlp_pkg::SETTLE_W-1:0];
            end
        end
    end

    // Saturating counter increments
    assign settle_inc = (&r_settle_count) ? r_settle_count : r_settle_count + 1'b1;
    assign hold_inc   = (&r_hold_count) ? r_hold_count : r_hold_count + 1'b1;

    // Next key state and event for the sample at the input
    always_comb begin
        n_mode         = r_mode;
        n_settle_count = r_settle_count;
        n_hold_count   = r_hold_count;
        n_press_event  = kdlp_pkg::EVT_NONE;
        case (r_mode)
            kdlp_pkg::MODE_RELEASED: begin
                // Start debouncing on a falling edge only
                if (!i_pin_level && r_prev_level) begin
                    n_mode         = kdlp_pkg::MODE_DEBOUNCE;
                    n_settle_count = '0;
                    n_hold_count   = '0;
                end
            end
            kdlp_pkg::MODE_DEBOUNCE: begin
                // Count low samples; a high sample aborts, counts kept
                if (!i_pin_level) begin
                    n_settle_count = settle_inc;
                    if (settle_inc >= r_debounce_limit) begin
                        n_mode = kdlp_pkg::MODE_PRESSED;
                    end
                end else begin
                    n_mode = kdlp_pkg::MODE_RELEASED;
                end
            end
            kdlp_pkg::MODE_PRESSED: begin
                if (!i_pin_level) begin
                    n_hold_count = hold_inc;
                    if (hold_inc >= r_long_press_limit) begin
                        n_mode        = kdlp_pkg::MODE_LONG;
                        n_press_event = kdlp_pkg::EVT_LONG;
                    end
                end else begin
                    // Release before the limit is a short press
                    if (r_hold_count < r_long_press_limit) begin
                        n_press_event = kdlp_pkg::EVT_SHORT;
                    end
                    n_mode         = kdlp_pkg::MODE_RELEASED;
                    n_settle_count = '0;
                    n_hold_count   = '0;
                end
            end
            kdlp_pkg::MODE_LONG: begin
                // Wait for release
                if (i_pin_level) begin
                    n_mode         = kdlp_pkg::MODE_RELEASED;
                    n_settle_count = '0;
                    n_hold_count   = '0;
                end
            end
            default: begin
                n_mode = kdlp_pkg::MODE_RELEASED;
            end
        endcase
    end

    // Advance key state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= kdlp_pkg::MODE_RELEASED;
            r_prev_level   <= 1'b1;
            r_settle_count <= '0;
            r_hold_count   <= '0;
        end else if (in_accept) begin
            r_mode         <= n_mode;
            r_prev_level   <= i_pin_level;
            r_settle_count <= n_settle_count;
            r_hold_count   <= n_hold_count;
        end
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_press_event <= n_press_event;
        end
    end

endmodule : key_debounce_long_press

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for key_debounce_long_press
// Drives pin samples through the valid/stall input channel and compares
// every event word on the output channel against an in-bench model of the
// debounce / long-press key machine. Both limits are reprogrammed over APB
// between phases and read back. Traffic has random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 250;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic                                i_pin_level;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [kdlp_pkg::EVENT_W-1:0]        o_press_event;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [kdlp_pkg::ADDR_W-1:0]         paddr;
    logic [kdlp_pkg::DATA_W-1:0]         pwdata;
    logic [kdlp_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    key_debounce_long_press i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pin_level   (i_pin_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_press_event (o_press_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Key machine copy and its limits
    logic [kdlp_pkg::SETTLE_W-1:0] debounce_limit;
    logic [kdlp_pkg::HOLD_W-1:0]   long_press_limit;
    logic [kdlp_pkg::MODE_W-1:0]   key_mode;
    logic                          prev_level;
    logic [kdlp_pkg::SETTLE_W-1:0] settle_cnt;
    logic [kdlp_pkg::HOLD_W-1:0]   hold_cnt;

    logic [kdlp_pkg::EVENT_W-1:0]  pending_events[$];
    int                            mismatch_count = 0;
    int                            event_count = 0;
    int                            samples_sent = 0;
    int                            burst_left = 0;
    int                            cycle_count = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic void reset_key_model();
        debounce_limit   = kdlp_pkg::DEBOUNCE_LIMIT_RST;
        long_press_limit = kdlp_pkg::LONG_PRESS_LIMIT_RST;
        key_mode         = kdlp_pkg::MODE_RELEASED;
        prev_level       = 1'b1;
        settle_cnt       = '0;
        hold_cnt         = '0;
    endfunction

    // Advance the key machine by one sample and return its event code
    function automatic logic [kdlp_pkg::EVENT_W-1:0] next_press_event(input logic lvl);
        logic [kdlp_pkg::EVENT_W-1:0] evt;
        evt = kdlp_pkg::EVT_NONE;
        case (key_mode)
            kdlp_pkg::MODE_RELEASED: begin
                // only a falling edge starts debouncing
                if (!lvl && prev_level) begin
                    key_mode   = kdlp_pkg::MODE_DEBOUNCE;
                    settle_cnt = '0;
                    hold_cnt   = '0;
                end
            end
            kdlp_pkg::MODE_DEBOUNCE: begin
                if (!lvl) begin
                    if (settle_cnt != '1)
                        settle_cnt = settle_cnt + 1'b1;
                    if (settle_cnt >= debounce_limit)
                        key_mode = kdlp_pkg::MODE_PRESSED;
                end else begin
                    // bounce: drop back, counters stay until next edge
                    key_mode = kdlp_pkg::MODE_RELEASED;
                end
            end
            kdlp_pkg::MODE_PRESSED: begin
                if (!lvl) begin
                    if (hold_cnt != '1)
                        hold_cnt = hold_cnt + 1'b1;
                    if (hold_cnt >= long_press_limit) begin
                        key_mode = kdlp_pkg::MODE_LONG;
                        evt      = kdlp_pkg::EVT_LONG;
                    end
                end else begin
                    if (hold_cnt < long_press_limit)
                        evt = kdlp_pkg::EVT_SHORT;
                    key_mode   = kdlp_pkg::MODE_RELEASED;
                    settle_cnt = '0;
                    hold_cnt   = '0;
                end
            end
            default: begin
                // long press: wait for release
                if (lvl) begin
                    key_mode   = kdlp_pkg::MODE_RELEASED;
                    settle_cnt = '0;
                    hold_cnt   = '0;
                end
            end
        endcase
        prev_level = lvl;
        return evt;
    endfunction

    // Send one sample word, with random gaps between bursts
    task automatic send_level(input logic lvl);
        int gap;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= lvl;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_events.push_back(next_press_event(lvl));
        samples_sent++;
        burst_left--;
    endtask

    task automatic hold_level(input logic lvl, input int count);
        repeat (count) send_level(lvl);
    endtask

    // Stop sending and wait until every event word has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write one limit register over APB, then read it back
    task automatic set_limit(input logic reg_idx, input logic [kdlp_pkg::DATA_W-1:0] data);
        logic [kdlp_pkg::DATA_W-1:0] stored;
        stored = (reg_idx == kdlp_pkg::REG_DEBOUNCE_LIMIT)
                 ? kdlp_pkg::DATA_W'(data[kdlp_pkg::SETTLE_W-1:0])
                 : kdlp_pkg::DATA_W'(data[kdlp_pkg::HOLD_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= kdlp_pkg::ADDR_W'({reg_idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // read-back setup follows the write access directly
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= '0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== stored)
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      reg_idx, prdata, stored));
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == kdlp_pkg::REG_DEBOUNCE_LIMIT)
            debounce_limit = data[kdlp_pkg::SETTLE_W-1:0];
        else
            long_press_limit = data[kdlp_pkg::HOLD_W-1:0];
    endtask

    task automatic set_limits(input logic [kdlp_pkg::DATA_W-1:0] deb,
                              input logic [kdlp_pkg::DATA_W-1:0] lng);
        wait_drained();
        set_limit(kdlp_pkg::REG_DEBOUNCE_LIMIT, deb);
        @(posedge i_clk);
        set_limit(kdlp_pkg::REG_LONG_PRESS_LIMIT, lng);
        @(posedge i_clk);
    endtask

    // Check each event word as it leaves; drive the output stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    initial i_out_stall <= 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("event word %0d with none expected",
                                          o_press_event));
            end else begin
                if (o_press_event !== pending_events[0])
                    report_mismatch($sformatf("event %0d: got %0d, expected %0d",
                                              event_count, o_press_event,
                                              pending_events[0]));
                void'(pending_events.pop_front());
            end
            event_count++;
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= cycle_count[0];
        endcase
    end

    // Reset limits: one short and one long press
    task automatic test_reset_limits();
        hold_level(1'b1, 2);
        hold_level(1'b0, 30);
        hold_level(1'b1, 2);
        hold_level(1'b0, 130);
        hold_level(1'b1, 1);
        wait_drained();
    endtask

    // Bounce, short, long, zero limits, wide register values
    task automatic test_special_cases();
        set_limits(32'hABCD_0102, 32'h1234_0003);
        // abort during debounce
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b1);
        // confirm, hold once, release: short press
        hold_level(1'b0, 4);
        send_level(1'b1);
        // hold to long press, keep holding, release
        hold_level(1'b0, 7);
        send_level(1'b1);
        set_limits(32'h0, 32'h0);
        // release right after confirm gives nothing with zero limits
        hold_level(1'b0, 2);
        send_level(1'b1);
        hold_level(1'b0, 3);
        send_level(1'b1);
        wait_drained();
    endtask

    // Largest and smallest limits
    task automatic test_limit_extremes();
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // still debouncing when released: no event
        hold_level(1'b0, 40);
        send_level(1'b1);
        set_limits(32'd1, 32'd1);
        hold_level(1'b0, 2);
        send_level(1'b1);
        hold_level(1'b0, 4);
        send_level(1'b1);
        wait_drained();
    endtask

    // Random presses with bounce, plus noise, under random limits
    task automatic test_random_presses();
        int deb;
        int lng;
        int bounces;
        int start;
        int next_cfg;
        start    = samples_sent;
        next_cfg = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS) begin
            if (samples_sent >= next_cfg) begin
                deb = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(0, 8);
                lng = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 120)
                                                  : $urandom_range(0, 20);
                set_limits(deb | ($urandom() & 32'hFFFF_FF00),
                           lng | ($urandom() & 32'hFFFF_0000));
                next_cfg = samples_sent + $urandom_range(60, 120);
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
            end else begin
                bounces = $urandom_range(0, 2);
                repeat (bounces) begin
                    hold_level(1'b0, $urandom_range(1, deb + 1));
                    hold_level(1'b1, $urandom_range(1, 2));
                end
                hold_level(1'b0, $urandom_range(1, deb + lng + 4));
                hold_level(1'b1, $urandom_range(1, 3));
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pin_level <= 1'b1;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        reset_key_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_limits();
        test_special_cases();
        test_limit_extremes();
        test_random_presses();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
